// ===== hw/rtl/wildcard_glob_matcher_defines.svh =====
// Assertion macros for the checker file of the wildcard glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WGM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/wgm_pkg.sv =====
// Constants, codes and widths shared by the wildcard glob matcher files.
package wgm_pkg;

   // Store capacities.
   localparam int PATTERN_MAX = 64;
   localparam int TEXT_MAX    = 256;

   // Length counters hold the capacity itself; indexes address the entries.
   localparam int PAT_LW = $clog2(PATTERN_MAX + 1);
   localparam int TXT_LW = $clog2(TEXT_MAX + 1);
   localparam int PAT_IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int TXT_IW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

   typedef logic [1:0] func_type;
   typedef logic [7:0] byte_type;

   // Item function codes.
   localparam func_type FUNC_PAT_APPEND = 2'd0;
   localparam func_type FUNC_TXT_APPEND = 2'd1;
   localparam func_type FUNC_EVALUATE   = 2'd2;
   localparam func_type FUNC_PAT_CLEAR  = 2'd3;

   // Wildcard characters of the pattern.
   localparam byte_type CH_ANY = 8'h3F;
   localparam byte_type CH_RUN = 8'h2A;

endpackage

// ===== hw/rtl/wgm_req_if.sv =====
// Request channel interface: function code and byte, with valid/ready.
interface wgm_req_if;
   import wgm_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   byte_type byte_value;

   modport source (output valid, output func, output byte_value, input ready);
   modport sink   (input valid, input func, input byte_value, output ready);
endinterface

// ===== hw/rtl/wgm_rsp_if.sv =====
// Response channel interface: match and overflow flags, with valid/ready.
interface wgm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflow;

   modport source (output valid, output matched, output overflow, input ready);
   modport sink   (input valid, input matched, input overflow, output ready);
endinterface

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher: byte stores and the matching sequencer.
//
// Items arrive on req_bus: func 0 appends byte_value to the pattern store,
// func 1 appends it to the text store, func 2 evaluates and func 3 clears the
// pattern. Only an evaluate item yields a response on rsp_bus, carrying
// matched and overflow; an overflowed store forces matched low.
// Append and clear items are handled while the sequencer stays idle. An
// evaluate item walks both stores with greedy matching and one backtrack
// point at the last '*'; each step of that walk is a synchronous memory
// read, then the decision. A store overflow skips the walk and goes straight
// to the result. The pattern and text memories each have one read port,
// which sets the pace of the walk. One item is worked on at a time;
// req_bus.ready is high whenever the sequencer is idle.
// Reset empties both stores logically (lengths and overflow flags cleared;
// memory contents are left as they are) and drops any pending response.
// A response waits in an output register while rsp_bus.ready is low; append
// and clear items are still taken meanwhile, and a following evaluation
// holds its result until the register is free.
module wildcard_glob_matcher (
   input logic         clock,
   input logic         reset,
   wgm_req_if.sink     req_bus,
   wgm_rsp_if.source   rsp_bus
);
   import wgm_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_TAIL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // Byte stores.
   byte_type pat_mem [PATTERN_MAX];
   byte_type txt_mem [TEXT_MAX];
   byte_type pat_q_ff;
   byte_type txt_q_ff;

   logic [2:0]        state_ff, state_in;
   logic [PAT_LW-1:0] plen_ff, plen_in;
   logic [TXT_LW-1:0] tlen_ff, tlen_in;
   logic              pov_ff, pov_in;
   logic              tov_ff, tov_in;
   logic [PAT_LW-1:0] p_ff, p_in;
   logic [PAT_LW-1:0] star_ff, star_in;
   logic [TXT_LW-1:0] t_ff, t_in;
   logic [TXT_LW-1:0] resume_ff, resume_in;
   logic              have_star_ff, have_star_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_matched_ff, rsp_matched_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic req_fire;
   logic rsp_free;
   logic pat_room;
   logic txt_room;
   logic p_live;
   logic any_ovf;
   logic pat_we;
   logic txt_we;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_fire         = req_bus.valid && req_bus.ready;
   assign rsp_free         = !rsp_valid_ff || rsp_bus.ready;
   assign pat_room         = (plen_ff < PAT_LW'(PATTERN_MAX));
   assign txt_room         = (tlen_ff < TXT_LW'(TEXT_MAX));
   assign p_live           = (p_ff < plen_ff);
   assign any_ovf          = pov_ff || tov_ff;
   assign pat_we           = req_fire && (req_bus.func == FUNC_PAT_APPEND) && pat_room;
   assign txt_we           = req_fire && (req_bus.func == FUNC_TXT_APPEND) && txt_room;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.matched  = rsp_matched_ff;
   assign rsp_bus.overflow = rsp_overflow_ff;

   // Memory writes at the current length, and registered reads at the walk pointers.
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[plen_ff[PAT_IW-1:0]] <= req_bus.byte_value;
      end
      if (txt_we) begin
         txt_mem[tlen_ff[TXT_IW-1:0]] <= req_bus.byte_value;
      end
      pat_q_ff <= pat_mem[p_ff[PAT_IW-1:0]];
      txt_q_ff <= txt_mem[t_ff[TXT_IW-1:0]];
   end

   // Next-state logic of the sequencer and the store bookkeeping.
   always_comb begin
      state_in        = state_ff;
      plen_in         = plen_ff;
      tlen_in         = tlen_ff;
      pov_in          = pov_ff;
      tov_in          = tov_ff;
      p_in            = p_ff;
      star_in         = star_ff;
      t_in            = t_ff;
      resume_in       = resume_ff;
      have_star_in    = have_star_ff;
      hit_in          = hit_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.func)
                  FUNC_PAT_APPEND: begin
                     if (pat_room) begin
                        plen_in = plen_ff + PAT_LW'(1);
                     end else begin
                        pov_in = 1'b1;
                     end
                  end
                  FUNC_TXT_APPEND: begin
                     if (txt_room) begin
                        tlen_in = tlen_ff + TXT_LW'(1);
                     end else begin
                        tov_in = 1'b1;
                     end
                  end
                  FUNC_EVALUATE: begin
                     p_in         = '0;
                     t_in         = '0;
                     star_in      = '0;
                     resume_in    = '0;
                     have_star_in = 1'b0;
                     hit_in       = 1'b0;
                     state_in     = any_ovf ? ST_DONE : ST_READ;
                  end
                  FUNC_PAT_CLEAR: begin
                     plen_in = '0;
                     pov_in  = 1'b0;
                  end
               endcase
            end
         end
         // The memories are read at p and t in this cycle; choose the next step.
         ST_READ: begin
            if (t_ff < tlen_ff) begin
               state_in = ST_EVAL;
            end else if (p_live) begin
               state_in = ST_TAIL;
            end else begin
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         // One step of the main walk over the text.
         ST_EVAL: begin
            state_in = ST_READ;
            if (p_live && (pat_q_ff == CH_RUN)) begin
               have_star_in = 1'b1;
               star_in      = p_ff;
               resume_in    = t_ff;
               p_in         = p_ff + PAT_LW'(1);
            end else if (p_live && ((pat_q_ff == CH_ANY) || (pat_q_ff == txt_q_ff))) begin
               p_in = p_ff + PAT_LW'(1);
               t_in = t_ff + TXT_LW'(1);
            end else if (have_star_ff) begin
               p_in      = star_ff + PAT_LW'(1);
               resume_in = resume_ff + TXT_LW'(1);
               t_in      = resume_ff + TXT_LW'(1);
            end else begin
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
         // Text used up: only trailing stars may remain in the pattern.
         ST_TAIL: begin
            if (pat_q_ff == CH_RUN) begin
               p_in     = p_ff + PAT_LW'(1);
               state_in = ST_READ;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
         // Hand the result to the output register and clear the text store.
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_matched_in  = hit_ff && !any_ovf;
               rsp_overflow_in = any_ovf;
               tlen_in         = '0;
               tov_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers are reset; the walk pointers and payload are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plen_ff      <= '0;
         tlen_ff      <= '0;
         pov_ff       <= 1'b0;
         tov_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         pov_ff       <= pov_in;
         tov_ff       <= tov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff            <= p_in;
      star_ff         <= star_in;
      t_ff            <= t_in;
      resume_ff       <= resume_in;
      have_star_ff    <= have_star_in;
      hit_ff          <= hit_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

endmodule

// ===== hw/rtl/wgm_checker.sv =====
// Port-level checker for the wildcard glob matcher and its bind statement.
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input wgm_pkg::func_type  req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_matched,
   input logic               rsp_overflow
);
   import wgm_pkg::*;

   logic req_fire;
   logic no_reset;

   assign req_fire = req_valid && req_ready;
   assign no_reset = 1'b0;

   // A response that is not taken stays offered.
   `WGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response withdrawn before it was taken")

   // An overflowed store never reports a match.
   `WGM_ASSERT_SAME(a_ovf_no_match, clock, reset, rsp_valid && rsp_overflow, !rsp_matched, "match reported despite overflow")

   // Reset leaves no response pending.
   `WGM_ASSERT_NEXT(a_reset_clear, clock, no_reset, reset, !rsp_valid, "response pending after reset")

   // Append and clear items produce no response of their own.
   `WGM_ASSERT_NEXT(a_no_spurious, clock, reset, req_fire && (req_func != FUNC_EVALUATE) && !rsp_valid, !rsp_valid, "response without an evaluate item")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_func     (req_bus.func),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_matched  (rsp_bus.matched),
   .rsp_overflow (rsp_bus.overflow)
);

// ===== test/tb_wildcard_glob_matcher.sv =====
// Self-checking testbench for the wildcard glob matcher: directed and random item streams.
`timescale 1ns / 100ps

module tb_wildcard_glob_matcher;
   import wgm_pkg::*;

   localparam int RANDOM_ITEMS = 150;
   localparam int DRAIN_CYCLES = 200;

   // Expected flags of one evaluation.
   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic clock;
   logic reset;

   wgm_req_if req_bus ();
   wgm_rsp_if rsp_bus ();

   wildcard_glob_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the block's stores, updated as each item is accepted.
   byte_type    shadow_pat [PATTERN_MAX];
   byte_type    shadow_txt [TEXT_MAX];
   int unsigned shadow_pat_len;
   int unsigned shadow_txt_len;
   bit          shadow_pat_ovf;
   bit          shadow_txt_ovf;

   verdict_type pending_verdicts [$];
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned responses_seen;
   bit          send_steady;

   always #5 clock = ~clock;

   // Greedy glob walk with a single backtrack point at the latest run wildcard.
   function automatic bit glob_walk();
      int unsigned p;
      int unsigned t;
      int unsigned star_at;
      int unsigned resume;
      bit          seen_star;
      p = 0;
      t = 0;
      star_at = 0;
      resume = 0;
      seen_star = 1'b0;
      while (t < shadow_txt_len) begin
         if (p < shadow_pat_len && shadow_pat[p] == CH_RUN) begin
            seen_star = 1'b1;
            star_at = p;
            resume = t;
            p++;
         end else if (p < shadow_pat_len &&
                      (shadow_pat[p] == CH_ANY || shadow_pat[p] == shadow_txt[t])) begin
            p++;
            t++;
         end else if (seen_star) begin
            p = star_at + 1;
            resume++;
            t = resume;
         end else begin
            return 1'b0;
         end
      end
      while (p < shadow_pat_len && shadow_pat[p] == CH_RUN) p++;
      return p == shadow_pat_len;
   endfunction

   // Apply one accepted item to the shadow state and queue any expected response.
   function automatic void predict_item(func_type f, byte_type b);
      verdict_type v;
      case (f)
         FUNC_PAT_APPEND: begin
            if (shadow_pat_len < PATTERN_MAX) begin
               shadow_pat[shadow_pat_len] = b;
               shadow_pat_len++;
            end else begin
               shadow_pat_ovf = 1'b1;
            end
         end
         FUNC_TXT_APPEND: begin
            if (shadow_txt_len < TEXT_MAX) begin
               shadow_txt[shadow_txt_len] = b;
               shadow_txt_len++;
            end else begin
               shadow_txt_ovf = 1'b1;
            end
         end
         FUNC_EVALUATE: begin
            v.overflow = shadow_pat_ovf | shadow_txt_ovf;
            v.matched  = v.overflow ? 1'b0 : glob_walk();
            pending_verdicts = {pending_verdicts, v};
            shadow_txt_len = 0;
            shadow_txt_ovf = 1'b0;
         end
         FUNC_PAT_CLEAR: begin
            shadow_pat_len = 0;
            shadow_pat_ovf = 1'b0;
         end
      endcase
   endfunction

   // Small alphabet so that random patterns and texts often agree.
   function automatic byte_type pick_symbol();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r <= 3) return "a";
      if (r <= 5) return "b";
      if (r == 6) return CH_RUN;
      if (r == 7) return CH_ANY;
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic flag_error(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Present one item after a random gap and hold it until the block takes it.
   task automatic send_item(func_type f, byte_type b);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= f;
      req_bus.byte_value <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_item(f, b);
      items_sent++;
   endtask

   task automatic put_string(func_type f, string s);
      for (int i = 0; i < s.len(); i++) send_item(f, s[i]);
   endtask

   task automatic put_run(func_type f, byte_type b, int unsigned count);
      repeat (count) send_item(f, b);
   endtask

   // Empty stores, run and single wildcards, and a literal star in the text.
   task automatic test_empty_and_wildcards();
      send_item(FUNC_EVALUATE, 8'hFF);
      put_string(FUNC_PAT_APPEND, "**");
      send_item(FUNC_EVALUATE, 8'h00);
      put_string(FUNC_TXT_APPEND, "*x");
      send_item(FUNC_EVALUATE, 8'h5A);
      send_item(FUNC_PAT_CLEAR, 8'hFF);
      put_string(FUNC_PAT_APPEND, "a*?b");
      put_string(FUNC_TXT_APPEND, "a*b");
      send_item(FUNC_EVALUATE, 8'hA5);
      send_item(FUNC_EVALUATE, 8'h00);
   endtask

   // Lowest and highest byte values in both stores.
   task automatic test_byte_extremes();
      send_item(FUNC_PAT_CLEAR, 8'h00);
      send_item(FUNC_PAT_APPEND, 8'h00);
      send_item(FUNC_PAT_APPEND, CH_ANY);
      send_item(FUNC_PAT_APPEND, CH_RUN);
      send_item(FUNC_PAT_APPEND, 8'hFF);
      send_item(FUNC_TXT_APPEND, 8'h00);
      send_item(FUNC_TXT_APPEND, 8'hFF);
      send_item(FUNC_TXT_APPEND, 8'hFF);
      send_item(FUNC_EVALUATE, 8'hFF);
      send_item(FUNC_TXT_APPEND, 8'h00);
      send_item(FUNC_TXT_APPEND, 8'hFF);
      send_item(FUNC_EVALUATE, 8'h00);
   endtask

   // Full stores with heavy backtracking, then overflow of each store.
   task automatic test_store_capacity();
      send_item(FUNC_PAT_CLEAR, 8'h00);
      send_item(FUNC_PAT_APPEND, CH_RUN);
      put_run(FUNC_PAT_APPEND, "a", PATTERN_MAX - 2);
      send_item(FUNC_PAT_APPEND, "b");
      put_run(FUNC_TXT_APPEND, "a", TEXT_MAX);
      send_item(FUNC_EVALUATE, 8'h00);
      // One byte too many for the text store.
      put_run(FUNC_TXT_APPEND, "a", TEXT_MAX);
      send_item(FUNC_TXT_APPEND, "b");
      send_item(FUNC_EVALUATE, 8'h00);
      // The evaluation cleared the text overflow.
      send_item(FUNC_TXT_APPEND, "b");
      send_item(FUNC_EVALUATE, 8'h00);
      // One byte too many for the pattern store; it persists over evaluations.
      send_item(FUNC_PAT_APPEND, "x");
      send_item(FUNC_TXT_APPEND, "a");
      send_item(FUNC_EVALUATE, 8'h00);
      send_item(FUNC_EVALUATE, 8'hFF);
      send_item(FUNC_PAT_CLEAR, 8'h00);
      put_string(FUNC_PAT_APPEND, "*a");
      put_run(FUNC_TXT_APPEND, "a", TEXT_MAX);
      send_item(FUNC_EVALUATE, 8'h00);
   endtask

   // Mostly pattern loads followed by texts derived from them, with some noise.
   task automatic test_random_sequences();
      int unsigned start;
      int unsigned n;
      int unsigned k;
      byte_type    text_bytes [$];
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(func_type'($urandom_range(0, 3)),
                                 byte_type'($urandom_range(0, 255)));
         end else begin
            // Usually a fresh pattern; rarely one long enough to overflow.
            if ($urandom_range(0, 3) != 0) begin
               send_item(FUNC_PAT_CLEAR, byte_type'($urandom_range(0, 255)));
               n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
               repeat (n) send_item(FUNC_PAT_APPEND, pick_symbol());
            end
            k = $urandom_range(1, 4);
            repeat (k) begin
               text_bytes.delete();
               if ($urandom_range(0, 49) == 0) begin
                  n = $urandom_range(250, 260);
                  repeat (n) text_bytes = {text_bytes, pick_symbol()};
               end else if ($urandom_range(0, 3) == 0) begin
                  n = $urandom_range(0, 12);
                  repeat (n) text_bytes = {text_bytes, pick_symbol()};
               end else begin
                  // Build a text that the current pattern should accept.
                  for (int i = 0; i < shadow_pat_len; i++) begin
                     if (shadow_pat[i] == CH_RUN)
                        repeat ($urandom_range(0, 3)) text_bytes = {text_bytes, pick_symbol()};
                     else if (shadow_pat[i] == CH_ANY)
                        text_bytes = {text_bytes, byte_type'($urandom_range(0, 255))};
                     else
                        text_bytes = {text_bytes, shadow_pat[i]};
                  end
               end
               // Occasionally spoil one byte.
               if ($urandom_range(0, 3) == 0) begin
                  if (text_bytes.size() > 0)
                     text_bytes[$urandom_range(0, text_bytes.size() - 1)] = pick_symbol();
                  else
                     text_bytes = {text_bytes, pick_symbol()};
               end
               foreach (text_bytes[i]) send_item(FUNC_TXT_APPEND, text_bytes[i]);
               // A missing evaluation leaves the text to run into the next one.
               if ($urandom_range(0, 9) != 0)
                  send_item(FUNC_EVALUATE, byte_type'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Response side: random stalls on ready, and a field-by-field check of each item.
   initial begin : response_checker
      int unsigned stall;
      bit          rsp_steady;
      verdict_type want;
      rsp_steady = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         responses_seen++;
         if (pending_verdicts.size() == 0) begin
            flag_error($sformatf("response %0d arrived with no evaluation outstanding",
                                 responses_seen));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.matched !== want.matched)
               flag_error($sformatf("response %0d matched %b, expected %b",
                                    responses_seen, rsp_bus.matched, want.matched));
            if (rsp_bus.overflow !== want.overflow)
               flag_error($sformatf("response %0d overflow %b, expected %b",
                                    responses_seen, rsp_bus.overflow, want.overflow));
         end
      end
   end

   // Watchdog.
   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence: reset, then each test in turn, then drain.
   initial begin
      clock = 1'b0;
      error_count = 0;
      items_sent = 0;
      responses_seen = 0;
      send_steady = 1'b0;
      shadow_pat_len = 0;
      shadow_txt_len = 0;
      shadow_pat_ovf = 1'b0;
      shadow_txt_ovf = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_PAT_CLEAR;
      req_bus.byte_value <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_wildcards();
      test_byte_extremes();
      test_store_capacity();
      test_random_sequences();

      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_req_if.sv
hw/rtl/wgm_rsp_if.sv
hw/rtl/wildcard_glob_matcher.sv
hw/rtl/wgm_checker.sv
test/tb_wildcard_glob_matcher.sv
